// ===== rtl/core/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants and types for the NMEA sentence framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 6;

  localparam logic [BYTE_W-1:0] START_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] START_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] LINE_FEED    = 8'h0A;

  localparam logic [CFG_W-1:0]  MIN_END_RESET = 6'd8;
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(STORE_DEPTH - 1);

  // Readout request from the capture side to the drain sequencer.
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] end_addr;
  } drain_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/nsf_ram.sv =====
// ----------------------------------------------------------------------------
// nsf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nsf_drain.sv =====
// ----------------------------------------------------------------------------
// nsf_drain
// Reads an accepted sentence out of the byte store and presents it on the
// output channel through an output register and a skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsf_drain (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire nsf_pkg::drain_cmd_t        cmd,
  output logic                            busy,
  output logic                            rd_en,
  output logic      [nsf_pkg::ADDR_W-1:0] rd_addr,
  input  wire logic [nsf_pkg::BYTE_W-1:0] rd_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [nsf_pkg::BYTE_W-1:0] out_sentence_byte,
  output logic                            out_sentence_last
);

  import nsf_pkg::*;

  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic              rd_vld_r, rd_last_r;
  logic              out_vld_r, out_vld_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              hold_vld_r, hold_vld_nxt;
  logic [BYTE_W-1:0] hold_byte_r, hold_byte_nxt;
  logic              hold_last_r, hold_last_nxt;
  logic              pop, issue, at_end, out_free;
  logic [1:0]        occ;

  assign pop    = out_vld_r && !out_stall;
  assign occ    = {1'b0, out_vld_r} + {1'b0, hold_vld_r} + {1'b0, rd_vld_r};
  // issue only when the beat will find a register to land in
  assign issue  = busy_r && ((occ <= 2'd1) || ((occ == 2'd2) && pop));
  assign at_end = (addr_r == end_r);

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    end_nxt  = end_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
      end_nxt  = cmd.end_addr;
    end else if (issue) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end
  end

  assign out_free = pop || !out_vld_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    hold_vld_nxt  = hold_vld_r;
    hold_byte_nxt = hold_byte_r;
    hold_last_nxt = hold_last_r;
    if (out_free) begin
      if (hold_vld_r) begin
        out_vld_nxt   = 1'b1;
        out_byte_nxt  = hold_byte_r;
        out_last_nxt  = hold_last_r;
        hold_vld_nxt  = rd_vld_r;
        hold_byte_nxt = rd_data;
        hold_last_nxt = rd_last_r;
      end else begin
        out_vld_nxt  = rd_vld_r;
        out_byte_nxt = rd_data;
        out_last_nxt = rd_last_r;
      end
    end else if (rd_vld_r) begin
      // output is stalled: park the arriving beat
      hold_vld_nxt  = 1'b1;
      hold_byte_nxt = rd_data;
      hold_last_nxt = rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      rd_vld_r   <= issue;
      out_vld_r  <= out_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
    addr_r      <= addr_nxt;
    end_r       <= end_nxt;
    rd_last_r   <= at_end;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_last_r <= hold_last_nxt;
  end

  assign busy              = busy_r;
  assign rd_en             = issue;
  assign rd_addr           = addr_r;
  assign out_valid         = out_vld_r;
  assign out_sentence_byte = out_byte_r;
  assign out_sentence_last = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/nmea_sentence_framer_core.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core
// Frames NMEA 0183 sentences out of a serial byte stream.
//
// Input channel: one received byte per beat (in_valid / in_stall).
// Output channel: the bytes of each accepted sentence in order, line feed
// included and flagged by out_sentence_last (out_valid / out_stall).
// Configuration: cfg_we writes cfg_min_end_index, the least line feed
// position of a sentence that is passed on (reset value 8).
// Bytes are taken one per cycle while a sentence is being collected.
// After the line feed beat of an accepted sentence, in_stall stays high
// while the sentence is read back from the byte store, one address per
// cycle on the single read port; the first byte then passes the drain's busy
// register, the store's registered read data and the output register, and
// the rest follow one per cycle. A stall on the output pauses the readout;
// an output and a skid register hold the pending beats, so no byte is lost.
// Reset returns the block to hunting for a start byte; the byte store is
// not cleared, as only freshly written positions are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [nsf_pkg::CFG_W-1:0]  cfg_min_end_index,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [nsf_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [nsf_pkg::BYTE_W-1:0] out_sentence_byte,
  output logic                            out_sentence_last
);

  import nsf_pkg::*;

  logic [CFG_W-1:0]  min_end_r, min_end_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic              in_sent_r, in_sent_nxt;
  logic              accept, is_start, drain_busy;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  drain_cmd_t        cmd;

  assign accept   = in_valid && !drain_busy;
  assign is_start = (in_rx_byte == START_DOLLAR) || (in_rx_byte == START_BANG);

  always_comb begin
    min_end_nxt  = cfg_we ? cfg_min_end_index : min_end_r;
    fill_nxt     = fill_r;
    in_sent_nxt  = in_sent_r;
    ram_we       = 1'b0;
    ram_waddr    = fill_r;
    cmd.start    = 1'b0;
    cmd.end_addr = fill_r;
    if (accept) begin
      if (!in_sent_r) begin
        if (is_start) begin
          ram_we      = 1'b1;
          ram_waddr   = '0;
          fill_nxt    = ADDR_W'(1);
          in_sent_nxt = 1'b1;
        end
      end else if (fill_r == LAST_ADDR) begin
        // store would fill: drop the partial sentence
        fill_nxt    = '0;
        in_sent_nxt = 1'b0;
      end else begin
        ram_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (in_rx_byte == LINE_FEED) begin
          fill_nxt    = '0;
          in_sent_nxt = 1'b0;
          cmd.start   = (CFG_W'(fill_r) >= min_end_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_end_r <= MIN_END_RESET;
      fill_r    <= '0;
      in_sent_r <= 1'b0;
    end else begin
      min_end_r <= min_end_nxt;
      fill_r    <= fill_nxt;
      in_sent_r <= in_sent_nxt;
    end
  end

  nsf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_rx_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  nsf_drain u_drain (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .busy             (drain_busy),
    .rd_en            (ram_re),
    .rd_addr          (ram_raddr),
    .rd_data          (ram_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sentence_byte(out_sentence_byte),
    .out_sentence_last(out_sentence_last)
  );

  assign in_stall = drain_busy;

endmodule

`default_nettype wire
